// ===== src/sht_pkg.sv =====
// shared types, register map and reset values for the staged heater thermostat
`default_nettype none

package sht_pkg;

  localparam int TempW    = 13;
  localparam int TimeW    = 32;
  localparam int DurW     = 24;
  localparam int StepW    = 16;
  localparam int WiperW   = 7;
  localparam int PosW     = 40;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 40;
  localparam int InDataW  = 64;
  localparam int OutDataW = 64;

  typedef enum logic [1:0] {
    LVL_OFF  = 2'd0,
    LVL_LOW  = 2'd1,
    LVL_MED  = 2'd2,
    LVL_HIGH = 2'd3
  } level_t;

  // register map
  localparam logic [CfgIdxW-1:0] REG_ON_HYST     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_OFF_HYST    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MED_THRESH  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_HIGH_THRESH = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MIN_ON      = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_MIN_OFF     = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_STEP_PERIOD = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_POSITIONS   = 3'd7;

  // byte lanes of the positions register
  localparam int POS_LOW  = 0;
  localparam int POS_MED  = 1;
  localparam int POS_HIGH = 2;
  localparam int POS_MIN  = 3;
  localparam int POS_MAX  = 4;

  typedef struct packed {
    logic signed [TempW-1:0] on_hysteresis;
    logic signed [TempW-1:0] off_hysteresis;
    logic signed [TempW-1:0] medium_threshold;
    logic signed [TempW-1:0] high_threshold;
    logic [DurW-1:0]         min_on_time;
    logic [DurW-1:0]         min_off_time;
    logic [StepW-1:0]        wiper_step_period;
    logic [PosW-1:0]         wiper_positions;
  } cfg_t;

  typedef struct packed {
    level_t              level;
    logic [WiperW-1:0]   wiper_pos;
    logic [TimeW-1:0]    on_since;
    logic [TimeW-1:0]    off_since;
    logic [TimeW-1:0]    last_step_time;
    logic                start_permit;
  } state_t;

  // first field in the highest bits
  typedef struct packed {
    logic signed [TempW-1:0] target_temp;
    logic signed [TempW-1:0] cabin_temp;
    logic                    enable;
    logic [TimeW-1:0]        now_ms;
  } in_item_t;

  typedef struct packed {
    logic [DurW-1:0]   wait_to_off;
    logic [DurW-1:0]   wait_to_on;
    logic              wiper_write;
    logic [WiperW-1:0] wiper;
    level_t            heat_level;
    logic              heater_on;
  } result_t;

  localparam cfg_t CFG_RESET = '{
    on_hysteresis:     13'sd16,
    off_hysteresis:    13'sd16,
    medium_threshold:  13'sd48,
    high_threshold:    13'sd80,
    min_on_time:       24'd60000,
    min_off_time:      24'd30000,
    wiper_step_period: 16'd50,
    wiper_positions:   40'd545467415572
  };

  localparam state_t STATE_RESET = '{
    level:          LVL_OFF,
    wiper_pos:      7'd20,
    on_since:       '0,
    off_since:      '0,
    last_step_time: '0,
    start_permit:   1'b1
  };

endpackage

`default_nettype wire

// ===== src/sht_step.sv =====
// next-state and result logic for one thermostat sample
`default_nettype none

module sht_step (
  input  var sht_pkg::cfg_t     cfg,
  input  var sht_pkg::state_t   st,
  input  var sht_pkg::in_item_t item,
  output sht_pkg::state_t       st_next,
  output sht_pkg::result_t      res
);
  import sht_pkg::*;

  logic [WiperW-1:0]       pos_low, pos_med, pos_high, pos_min, pos_max;
  logic signed [TempW:0]   shortfall;
  logic signed [TempW:0]   off_limit;
  logic [TimeW-1:0]        on_el, off_el, step_el;
  logic [TimeW-1:0]        on_el_new, off_el_new;
  logic                    can_on, can_off;
  level_t                  staged, want;
  logic                    changed, to_off, to_on;
  logic [WiperW-1:0]       wiper_mid, goal_raw, goal;
  logic                    step_go;
  logic                    permit_new;

  function automatic logic [WiperW-1:0] clamp(input logic [WiperW-1:0] v,
                                              input logic [WiperW-1:0] lo,
                                              input logic [WiperW-1:0] hi);
    logic [WiperW-1:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign pos_low  = cfg.wiper_positions[8*POS_LOW  +: WiperW];
  assign pos_med  = cfg.wiper_positions[8*POS_MED  +: WiperW];
  assign pos_high = cfg.wiper_positions[8*POS_HIGH +: WiperW];
  assign pos_min  = cfg.wiper_positions[8*POS_MIN  +: WiperW];
  assign pos_max  = cfg.wiper_positions[8*POS_MAX  +: WiperW];

  assign shortfall = (TempW+1)'(item.target_temp) - (TempW+1)'(item.cabin_temp);
  assign off_limit = (TempW+1)'(item.target_temp) + (TempW+1)'(cfg.off_hysteresis);

  assign on_el   = item.now_ms - st.off_since;
  assign off_el  = item.now_ms - st.on_since;
  assign step_el = item.now_ms - st.last_step_time;

  assign can_on  = st.start_permit || (on_el >= TimeW'(cfg.min_off_time));
  assign can_off = off_el >= TimeW'(cfg.min_on_time);

  always_comb begin
    if (shortfall >= (TempW+1)'(cfg.high_threshold)) begin
      staged = LVL_HIGH;
    end else if (shortfall >= (TempW+1)'(cfg.medium_threshold)) begin
      staged = LVL_MED;
    end else begin
      staged = LVL_LOW;
    end
  end

  always_comb begin
    want = st.level;
    if (!item.enable) begin
      want = LVL_OFF;
    end else if (st.level == LVL_OFF) begin
      if (shortfall >= (TempW+1)'(cfg.on_hysteresis) && can_on) begin
        want = staged;
      end
    end else if ((TempW+1)'(item.cabin_temp) >= off_limit && can_off) begin
      want = LVL_OFF;
    end else begin
      want = staged;
    end
  end

  assign changed = want != st.level;
  assign to_off  = changed && (want == LVL_OFF);
  assign to_on   = changed && (want != LVL_OFF);

  // parking on the way to off, then slew toward the level's position
  assign wiper_mid = to_off ? clamp(pos_low, pos_min, pos_max) : st.wiper_pos;

  always_comb begin
    case (want)
      LVL_MED:  goal_raw = pos_med;
      LVL_HIGH: goal_raw = pos_high;
      default:  goal_raw = pos_low;
    endcase
  end

  assign goal    = clamp(goal_raw, pos_min, pos_max);
  assign step_go = item.enable && (step_el >= TimeW'(cfg.wiper_step_period)) &&
                   (wiper_mid != goal);

  assign permit_new = st.start_permit && !to_off;

  always_comb begin
    st_next                = st;
    st_next.level          = want;
    st_next.start_permit   = permit_new;
    st_next.off_since      = to_off ? item.now_ms : st.off_since;
    st_next.on_since       = to_on ? item.now_ms : st.on_since;
    st_next.wiper_pos      = wiper_mid;
    if (step_go) begin
      st_next.wiper_pos      = (wiper_mid < goal) ? wiper_mid + 1'b1 : wiper_mid - 1'b1;
      st_next.last_step_time = item.now_ms;
    end
  end

  // a stamp refreshed this sample means zero elapsed time
  assign on_el_new  = to_off ? '0 : on_el;
  assign off_el_new = to_on ? '0 : off_el;

  always_comb begin
    res.heater_on   = want != LVL_OFF;
    res.heat_level  = want;
    res.wiper       = st_next.wiper_pos;
    res.wiper_write = to_off || step_go;
    if (permit_new || on_el_new >= TimeW'(cfg.min_off_time)) begin
      res.wait_to_on = '0;
    end else begin
      res.wait_to_on = cfg.min_off_time - on_el_new[DurW-1:0];
    end
    if (off_el_new >= TimeW'(cfg.min_on_time)) begin
      res.wait_to_off = '0;
    end else begin
      res.wait_to_off = cfg.min_on_time - off_el_new[DurW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== src/staged_heater_thermostat_top.sv =====
// top level of the staged heater thermostat: stream ports, config registers, state
`default_nettype none

// Staged heater thermostat. Each input beat carries a millisecond stamp, an
// enable bit and the cabin and target temperatures; each one gives exactly one
// output beat with the heat level, the potentiometer wiper position, a wiper
// write flag and the remaining minimum on and off waits. The block takes one
// beat per clock at full rate while the output is not stalled: a beat lands
// in an input register, and the thermostat state and the result register are
// updated from it once the result register is free or being read. The state
// update is a combinational loop (stamp subtractions, threshold compares, level
// choice), which is what lets the next beat follow right behind. Configuration
// writes are taken on any cycle with cfg_we high and should only be issued while
// no beat is in flight.
module staged_heater_thermostat_top (
  input  wire                           clk,
  input  wire                           rst,
  // input stream
  input  wire                           s_tvalid,
  output logic                          s_tready,
  // tdata: now_ms[31:0], enable[32], cabin_temp[45:33], target_temp[58:46], zero pad
  input  wire  [sht_pkg::InDataW-1:0]   s_tdata,
  // output stream
  output logic                          m_tvalid,
  input  wire                           m_tready,
  // tdata: heater_on[0], heat_level[2:1], wiper[9:3], wiper_write[10],
  //        wait_to_on[34:11], wait_to_off[58:35], zero pad
  output logic [sht_pkg::OutDataW-1:0]  m_tdata,
  // register write port
  input  wire                           cfg_we,
  input  wire  [sht_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire  [sht_pkg::CfgDataW-1:0]  cfg_data
);
  import sht_pkg::*;

  localparam int ItemW = $bits(in_item_t);
  localparam int ResW  = $bits(result_t);

  cfg_t     cfg;
  state_t   st;
  state_t   st_next;
  in_item_t in_item;
  logic     in_valid;
  result_t  res_next;
  result_t  res;
  logic     fire;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ON_HYST:     cfg.on_hysteresis     <= cfg_data[TempW-1:0];
        REG_OFF_HYST:    cfg.off_hysteresis    <= cfg_data[TempW-1:0];
        REG_MED_THRESH:  cfg.medium_threshold  <= cfg_data[TempW-1:0];
        REG_HIGH_THRESH: cfg.high_threshold    <= cfg_data[TempW-1:0];
        REG_MIN_ON:      cfg.min_on_time       <= cfg_data[DurW-1:0];
        REG_MIN_OFF:     cfg.min_off_time      <= cfg_data[DurW-1:0];
        REG_STEP_PERIOD: cfg.wiper_step_period <= cfg_data[StepW-1:0];
        REG_POSITIONS:   cfg.wiper_positions   <= cfg_data[PosW-1:0];
        default: ;
      endcase
    end
  end

  // the update fires when a sample is waiting and the result slot frees up
  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item <= in_item_t'(s_tdata[ItemW-1:0]);
    end
  end

  sht_step u_step (
    .cfg     (cfg),
    .st      (st),
    .item    (in_item),
    .st_next (st_next),
    .res     (res_next)
  );

  // thermostat state, advanced once per sample
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (fire) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

  assign m_tdata = {(OutDataW-ResW)'(0), res};

  // going off always revokes the free first start
  a_off_revokes_permit: assert property (@(posedge clk) disable iff (rst)
    fire && st.level != LVL_OFF && st_next.level == LVL_OFF |=> !st.start_permit)
    else $error("start permit kept after turning off");

  // the wiper only moves on a beat that reports a wiper write
  a_wiper_moves_with_write: assert property (@(posedge clk) disable iff (rst)
    fire && !res_next.wiper_write |-> st_next.wiper_pos == st.wiper_pos)
    else $error("wiper moved without a write");

  // a waiting sample is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    in_valid && !fire |-> !s_tready)
    else $error("input register overwritten");

  // the reported level is the level held for the next sample
  a_level_matches_state: assert property (@(posedge clk) disable iff (rst)
    fire |=> res.heat_level == st.level && res.heater_on == (st.level != LVL_OFF))
    else $error("reported level differs from state");

endmodule

`default_nettype wire
